>>> rtl/iso_ts_pkg.sv
// Shared types, constants and tables for the ISO 8601 timestamp to epoch converter.
// No dependencies; every other file of the block refers to this package.
`default_nettype none

package iso_ts_pkg;

   // Length limits of one timestamp string.
   localparam int MAX_CHARS = 20;
   localparam int SHORT_LEN = 17;
   localparam int COUNT_MAX = 31;
   localparam int ACC_MAX   = 16383;

   // Field ranges.
   localparam int YEAR_MIN   = 1900;
   localparam int YEAR_MAX   = 2100;
   localparam int MONTH_MAX  = 12;
   localparam int DAY_MAX    = 31;
   localparam int HOUR_MAX   = 23;
   localparam int MINSEC_MAX = 59;

   // Year offsets, counted from 1900.
   localparam int EPOCH_YEAR_OFFSET = 70;
   localparam int LEAP_BASE_OFFSET  = 69;
   localparam int CENTURY_2000      = 100;
   localparam int CENTURY_2100      = 200;

   // Time constants.
   localparam int DAYS_PER_YEAR   = 365;
   localparam int SECS_PER_DAY    = 86400;
   localparam int SECS_PER_HOUR   = 3600;
   localparam int SECS_PER_MINUTE = 60;
   localparam int FEBRUARY        = 2;

   // Characters of the timestamp grammar.
   localparam logic [7:0] CHAR_ZERO  = 8'h30;
   localparam logic [7:0] CHAR_NINE  = 8'h39;
   localparam logic [7:0] CHAR_DASH  = 8'h2D;
   localparam logic [7:0] CHAR_COLON = 8'h3A;
   localparam logic [7:0] CHAR_T     = 8'h54;
   localparam logic [7:0] CHAR_Z     = 8'h5A;

   typedef struct packed {
      logic [7:0] character;
      logic       last_char;
   } req_type;

   typedef struct packed {
      logic [31:0] epoch_seconds;
      logic        parse_error;
   } rsp_type;

   // Parsed fields of one finished string.
   typedef struct packed {
      logic       err;
      logic [7:0] year_offset;
      logic [3:0] month;
      logic [4:0] day;
      logic [4:0] hour;
      logic [5:0] minute;
      logic [5:0] second;
   } fields_type;

   // Days in the year before the first of the given month, not counting a leap day.
   function automatic logic [8:0] cum_days(input logic [3:0] month);
      logic [8:0] d;
      unique case (month)
         4'd1:    d = 9'd0;
         4'd2:    d = 9'd31;
         4'd3:    d = 9'd59;
         4'd4:    d = 9'd90;
         4'd5:    d = 9'd120;
         4'd6:    d = 9'd151;
         4'd7:    d = 9'd181;
         4'd8:    d = 9'd212;
         4'd9:    d = 9'd243;
         4'd10:   d = 9'd273;
         4'd11:   d = 9'd304;
         4'd12:   d = 9'd334;
         default: d = 9'd0;
      endcase
      return d;
   endfunction

endpackage

`default_nettype wire

>>> rtl/iso_ts_parser.sv
// Character parser: walks the timestamp string one character per transaction and
// registers the parsed fields when the final character arrives. Uses iso_ts_pkg.
`default_nettype none

module iso_ts_parser (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 accept,
   input  wire logic                 advance,
   input  wire iso_ts_pkg::req_type  req_data,
   output logic                      fields_valid,
   output iso_ts_pkg::fields_type    fields_data
);

   typedef enum logic [5:0] {
      FIELD_YEAR   = 6'b000001,
      FIELD_MONTH  = 6'b000010,
      FIELD_DAY    = 6'b000100,
      FIELD_HOUR   = 6'b001000,
      FIELD_MINUTE = 6'b010000,
      FIELD_SECOND = 6'b100000
   } field_type;

   field_type   field_ff, field_in;
   logic [13:0] acc_ff, acc_in;
   logic [7:0]  year_ff, year_in;
   logic [3:0]  month_ff, month_in;
   logic [4:0]  day_ff, day_in;
   logic [4:0]  hour_ff, hour_in;
   logic [5:0]  minute_ff, minute_in;
   logic [4:0]  char_cnt_ff, char_cnt_in;
   logic [4:0]  content_cnt_ff, content_cnt_in;
   logic        z_seen_ff, z_seen_in;
   logic        err_ff, err_in;
   logic        run_open_ff, run_open_in;

   logic                   fields_valid_ff, fields_valid_in;
   iso_ts_pkg::fields_type fields_ff, fields_in;

   logic [7:0]  ch;
   logic [7:0]  sep;
   logic        has_sep;
   field_type   field_next;
   logic [17:0] acc_sum;
   logic        is_digit;
   logic        short_str;
   logic        acc_over_59;

   assign ch = req_data.character;
   assign is_digit = (ch >= iso_ts_pkg::CHAR_ZERO) && (ch <= iso_ts_pkg::CHAR_NINE);
   assign acc_sum = 18'(acc_ff) * 18'd10 + 18'(ch[3:0]);

   // Separator that closes the current field, and the field that follows it.
   always_comb begin
      sep        = iso_ts_pkg::CHAR_DASH;
      has_sep    = 1'b1;
      field_next = FIELD_YEAR;
      unique case (field_ff)
         FIELD_YEAR: begin
            sep        = iso_ts_pkg::CHAR_DASH;
            field_next = FIELD_MONTH;
         end
         FIELD_MONTH: begin
            sep        = iso_ts_pkg::CHAR_DASH;
            field_next = FIELD_DAY;
         end
         FIELD_DAY: begin
            sep        = iso_ts_pkg::CHAR_T;
            field_next = FIELD_HOUR;
         end
         FIELD_HOUR: begin
            sep        = iso_ts_pkg::CHAR_COLON;
            field_next = FIELD_MINUTE;
         end
         FIELD_MINUTE: begin
            sep        = iso_ts_pkg::CHAR_COLON;
            field_next = FIELD_SECOND;
         end
         default: begin
            has_sep    = 1'b0;
            field_next = FIELD_SECOND;
         end
      endcase
   end

   // Effect of one character on the parse state.
   always_comb begin
      field_in       = field_ff;
      acc_in         = acc_ff;
      year_in        = year_ff;
      month_in       = month_ff;
      day_in         = day_ff;
      hour_in        = hour_ff;
      minute_in      = minute_ff;
      char_cnt_in    = char_cnt_ff;
      content_cnt_in = content_cnt_ff;
      z_seen_in      = z_seen_ff;
      err_in         = err_ff;
      run_open_in    = run_open_ff;

      if (char_cnt_ff >= 5'(iso_ts_pkg::MAX_CHARS)) begin
         err_in = 1'b1;
      end else begin
         char_cnt_in = char_cnt_ff + 5'd1;
      end

      if (!z_seen_ff) begin
         if (ch == iso_ts_pkg::CHAR_Z) begin
            z_seen_in = 1'b1;
         end else begin
            if (content_cnt_ff < 5'(iso_ts_pkg::COUNT_MAX)) begin
               content_cnt_in = content_cnt_ff + 5'd1;
            end
            if (has_sep && ch == sep) begin
               // Close the current field with its range check.
               unique case (field_ff)
                  FIELD_YEAR: begin
                     if (acc_ff < 14'(iso_ts_pkg::YEAR_MIN) ||
                         acc_ff > 14'(iso_ts_pkg::YEAR_MAX)) begin
                        err_in = 1'b1;
                     end else begin
                        year_in = 8'(acc_ff - 14'(iso_ts_pkg::YEAR_MIN));
                     end
                  end
                  FIELD_MONTH: begin
                     if (acc_ff < 14'd1 || acc_ff > 14'(iso_ts_pkg::MONTH_MAX)) begin
                        err_in = 1'b1;
                     end else begin
                        month_in = acc_ff[3:0];
                     end
                  end
                  FIELD_DAY: begin
                     if (acc_ff < 14'd1 || acc_ff > 14'(iso_ts_pkg::DAY_MAX)) begin
                        err_in = 1'b1;
                     end else begin
                        day_in = acc_ff[4:0];
                     end
                  end
                  FIELD_HOUR: begin
                     if (acc_ff > 14'(iso_ts_pkg::HOUR_MAX)) begin
                        err_in = 1'b1;
                     end else begin
                        hour_in = acc_ff[4:0];
                     end
                  end
                  FIELD_MINUTE: begin
                     if (acc_ff > 14'(iso_ts_pkg::MINSEC_MAX)) begin
                        err_in = 1'b1;
                     end else begin
                        minute_in = acc_ff[5:0];
                     end
                  end
                  default: begin
                  end
               endcase
               acc_in      = '0;
               run_open_in = 1'b1;
               field_in    = field_next;
            end else if (run_open_ff && is_digit) begin
               acc_in = (acc_sum > 18'(iso_ts_pkg::ACC_MAX)) ?
                        14'(iso_ts_pkg::ACC_MAX) : acc_sum[13:0];
            end else begin
               run_open_in = 1'b0;
            end
         end
      end
   end

   // Final close on the last character, working on the state after that character.
   assign short_str   = content_cnt_in < 5'(iso_ts_pkg::SHORT_LEN);
   assign acc_over_59 = acc_in > 14'(iso_ts_pkg::MINSEC_MAX);

   always_comb begin
      fields_in.year_offset = year_in;
      fields_in.month       = month_in;
      fields_in.day         = day_in;
      fields_in.hour        = hour_in;
      fields_in.minute      = minute_in;
      fields_in.second      = '0;
      fields_in.err         = err_in;
      unique case (field_in)
         FIELD_MINUTE: begin
            // Minute still open: close it; the second is absent.
            if (acc_over_59 || !short_str) begin
               fields_in.err = 1'b1;
            end
            if (!acc_over_59) begin
               fields_in.minute = acc_in[5:0];
            end
         end
         FIELD_SECOND: begin
            if (!short_str) begin
               if (acc_over_59) begin
                  fields_in.err = 1'b1;
               end else begin
                  fields_in.second = acc_in[5:0];
               end
            end
         end
         default: begin
            // The string ended before the minute field.
            fields_in.err = 1'b1;
         end
      endcase
   end

   assign fields_valid_in = accept && req_data.last_char;

   always_ff @(posedge clock) begin
      if (reset || (accept && req_data.last_char)) begin
         field_ff       <= FIELD_YEAR;
         acc_ff         <= '0;
         year_ff        <= '0;
         month_ff       <= '0;
         day_ff         <= '0;
         hour_ff        <= '0;
         minute_ff      <= '0;
         char_cnt_ff    <= '0;
         content_cnt_ff <= '0;
         z_seen_ff      <= 1'b0;
         err_ff         <= 1'b0;
         run_open_ff    <= 1'b1;
      end else if (accept) begin
         field_ff       <= field_in;
         acc_ff         <= acc_in;
         year_ff        <= year_in;
         month_ff       <= month_in;
         day_ff         <= day_in;
         hour_ff        <= hour_in;
         minute_ff      <= minute_in;
         char_cnt_ff    <= char_cnt_in;
         content_cnt_ff <= content_cnt_in;
         z_seen_ff      <= z_seen_in;
         err_ff         <= err_in;
         run_open_ff    <= run_open_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fields_valid_ff <= 1'b0;
      end else if (advance) begin
         fields_valid_ff <= fields_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         fields_ff <= fields_in;
      end
   end

   assign fields_valid = fields_valid_ff;
   assign fields_data  = fields_ff;

endmodule

`default_nettype wire

>>> rtl/iso_ts_epoch.sv
// Epoch arithmetic: turns parsed date and time fields into seconds since 1970
// over two registered steps, the second of which is the result register. Uses iso_ts_pkg.
`default_nettype none

module iso_ts_epoch (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    advance,
   input  wire logic                    fields_valid,
   input  wire iso_ts_pkg::fields_type  fields_data,
   output logic                         rsp_valid,
   output iso_ts_pkg::rsp_type          rsp_data
);

   typedef struct packed {
      logic               err;
      logic signed [17:0] days;
      logic [16:0]        sod;
   } days_type;

   logic               days_valid_ff;
   days_type           days_ff, days_in;
   logic               rsp_valid_ff;
   iso_ts_pkg::rsp_type rsp_ff, rsp_in;

   logic [7:0]         y;
   logic signed [9:0]  yoff;
   logic signed [17:0] ybase;
   logic signed [9:0]  v;
   logic [9:0]         vmag;
   logic [7:0]         qmag;
   logic signed [17:0] qterm;
   logic               leap;
   logic               leap_add;
   logic signed [35:0] prod;

   assign y     = fields_data.year_offset;
   assign yoff  = $signed({2'b00, y}) - 10'sd70;
   assign ybase = 18'(yoff) * 18'(iso_ts_pkg::DAYS_PER_YEAR);

   // Leap days since 1970, with the quotient truncated toward zero. Over years
   // 1900..2100 the century and 400-year terms of the formula cancel.
   assign v     = $signed({2'b00, y}) - 10'(iso_ts_pkg::LEAP_BASE_OFFSET);
   assign vmag  = v[9] ? 10'(-v) : 10'(v);
   assign qmag  = vmag[9:2];
   assign qterm = v[9] ? -$signed({10'b0, qmag}) : $signed({10'b0, qmag});

   // Since 1900 is divisible by four, the year offset decides leap years; 1900
   // and 2100 are the century years that are not, 2000 is.
   assign leap = (y[1:0] == 2'b00) &&
                 ((y != 8'd0 && y != 8'(iso_ts_pkg::CENTURY_2100)) ||
                  y == 8'(iso_ts_pkg::CENTURY_2000));
   assign leap_add = leap && (fields_data.month > 4'(iso_ts_pkg::FEBRUARY));

   always_comb begin
      days_in.err  = fields_data.err;
      days_in.days = ybase + qterm
                   + $signed({9'b0, iso_ts_pkg::cum_days(fields_data.month)})
                   + $signed({17'b0, leap_add})
                   + $signed({13'b0, fields_data.day}) - 18'sd1;
      days_in.sod  = 17'(fields_data.hour) * 17'(iso_ts_pkg::SECS_PER_HOUR)
                   + 17'(fields_data.minute) * 17'(iso_ts_pkg::SECS_PER_MINUTE)
                   + 17'(fields_data.second);
   end

   assign prod = 36'(days_ff.days) * 36'(iso_ts_pkg::SECS_PER_DAY);

   always_comb begin
      rsp_in.parse_error   = days_ff.err;
      rsp_in.epoch_seconds = days_ff.err ? '0 : prod[31:0] + 32'(days_ff.sod);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         days_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else if (advance) begin
         days_valid_ff <= fields_valid;
         rsp_valid_ff  <= days_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         days_ff <= days_in;
         rsp_ff  <= rsp_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

`default_nettype wire

>>> rtl/iso8601_timestamp_to_epoch.sv
// Top level of the ISO 8601 timestamp to epoch converter.
// Instantiates iso_ts_parser and iso_ts_epoch; uses iso_ts_pkg.
//
// Usage: the string "yyyy-mm-ddThh:mm[:ss][Z]" is sent one character per
// transaction on the req_ channel, with last_char set on its final character.
// Every string yields exactly one transaction on the rsp_ channel: the seconds
// since 1970-01-01 00:00:00 modulo 2^32 and a parse_error flag (seconds are zero
// when the flag is set). Characters after the first Z are ignored but counted,
// and a string of more than 20 characters is flagged as an error.
//
// Throughput: a new character is taken in every cycle unless the output stalls.
// The result is presented once the final character has passed the parsed-fields
// register, the day-count register and the result register; these form a
// three-step pipeline, the day-count and seconds multiplies in separate steps.
//
// Stalls: the pipeline moves as a whole. While a result waits in the output
// register and rsp_ready is low, req_ready is low and all stages hold; while the
// output register is empty or being drained, req_ready is high.
//
// Reset: synchronous and active high. It empties the pipeline and returns the
// parser to the start of a string.
`default_nettype none

module iso8601_timestamp_to_epoch (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 req_valid,
   output logic                      req_ready,
   input  wire iso_ts_pkg::req_type  req_data,
   output logic                      rsp_valid,
   input  wire logic                 rsp_ready,
   output iso_ts_pkg::rsp_type       rsp_data
);

   logic                   advance;
   logic                   accept;
   logic                   fields_valid;
   iso_ts_pkg::fields_type fields_data;

   // The whole pipeline advances unless a result is stuck in the output register.
   assign advance   = !rsp_valid || rsp_ready;
   assign req_ready = advance;
   assign accept    = req_valid && req_ready;

   iso_ts_parser u_parser (
      .clock        (clock),
      .reset        (reset),
      .accept       (accept),
      .advance      (advance),
      .req_data     (req_data),
      .fields_valid (fields_valid),
      .fields_data  (fields_data)
   );

   iso_ts_epoch u_epoch (
      .clock        (clock),
      .reset        (reset),
      .advance      (advance),
      .fields_valid (fields_valid),
      .fields_data  (fields_data),
      .rsp_valid    (rsp_valid),
      .rsp_data     (rsp_data)
   );

endmodule

`default_nettype wire

>>> rtl/iso_ts_checker.sv
// Port-level checks for the ISO 8601 timestamp to epoch converter, bound to its
// top level. Uses iso_ts_pkg.
`default_nettype none

module iso_ts_checker (
   input wire logic                 clock,
   input wire logic                 reset,
   input wire logic                 req_valid,
   input wire logic                 req_ready,
   input wire iso_ts_pkg::req_type  req_data,
   input wire logic                 rsp_valid,
   input wire logic                 rsp_ready,
   input wire iso_ts_pkg::rsp_type  rsp_data
);

   // A stalled result holds its value.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("stalled result transaction changed");

   // An erroneous result carries zero seconds.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.parse_error |-> rsp_data.epoch_seconds == 32'd0)
      else $error("error result with nonzero seconds");

   // With the output register empty the block must take characters.
   assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> req_ready)
      else $error("input stalled while output is empty");

   // Reset empties the output register.
   assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result present after reset");

   // A character accepted while the output is stalled is impossible.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |-> !(req_valid && req_ready))
      else $error("input accepted during output stall");

endmodule

bind iso8601_timestamp_to_epoch iso_ts_checker u_iso_ts_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_ready (req_ready),
   .req_data  (req_data),
   .rsp_valid (rsp_valid),
   .rsp_ready (rsp_ready),
   .rsp_data  (rsp_data)
);

`default_nettype wire
